// ===== hdl/vtb_pkg.sv =====
// Shared types and constants for the vertex transform with bounds block.
// No dependencies; used by every module under hdl.
package vtb_pkg;

	localparam int PosW      = 32;
	localparam int NrmW      = 16;
	localparam int TexW      = 32;
	localparam int CoefW     = 16;
	localparam int RowW      = 48;
	localparam int OffW      = 32;
	localparam int CfgIdxW   = 3;
	localparam int CfgDataW  = 48;
	localparam int DataW     = 208;
	localparam int KindW     = 2;
	localparam int FracShift = 12;
	localparam int QueueDepthDefault = 2;

	localparam logic [RowW-1:0] RowXReset = 48'h0000_0000_1000;
	localparam logic [RowW-1:0] RowYReset = 48'h0000_1000_0000;
	localparam logic [RowW-1:0] RowZReset = 48'h1000_0000_0000;

	// Result kinds carried on the output tuser.
	typedef enum logic [KindW-1:0] {
		KIND_VERTEX = 2'd0,
		KIND_MIN    = 2'd1,
		KIND_MAX    = 2'd2
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CfgIdxW-1:0] {
		CFG_ROW_X = 3'd0,
		CFG_ROW_Y = 3'd1,
		CFG_ROW_Z = 3'd2,
		CFG_OFF_X = 3'd3,
		CFG_OFF_Y = 3'd4,
		CFG_OFF_Z = 3'd5
	} cfg_idx_t;

	// One accepted vertex as it leaves the front part.
	typedef struct packed {
		logic signed [PosW-1:0] pos_x;
		logic signed [PosW-1:0] pos_y;
		logic signed [PosW-1:0] pos_z;
		logic signed [NrmW-1:0] nrm_x;
		logic signed [NrmW-1:0] nrm_y;
		logic signed [NrmW-1:0] nrm_z;
		logic [TexW-1:0]        tex_u;
		logic [TexW-1:0]        tex_v;
		logic                   mesh_start;
		logic                   last_vertex;
	} vtb_item_t;

	// Configuration seen by the back part.
	typedef struct packed {
		logic [RowW-1:0]        row_x;
		logic [RowW-1:0]        row_y;
		logic [RowW-1:0]        row_z;
		logic signed [OffW-1:0] off_x;
		logic signed [OffW-1:0] off_y;
		logic signed [OffW-1:0] off_z;
	} vtb_cfg_t;

	// Back part sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_SQ,
		ST_ROOT_INIT,
		ST_ROOT,
		ST_DIV_INIT,
		ST_DIV,
		ST_FIX,
		ST_EMIT_V,
		ST_EMIT_MIN,
		ST_EMIT_MAX
	} state_t;

endpackage

// ===== hdl/vtb_front.sv =====
// Front part: accepts vertex transactions, unpacks them and queues them.
// Depends on vtb_pkg.
module vtb_front #(
	parameter int QueueDepth = vtb_pkg::QueueDepthDefault
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v
	input  logic [vtb_pkg::DataW-1:0] s_tdata,
	// mesh start flag
	input  logic                      s_tuser,
	input  logic                      s_tlast,
	output vtb_pkg::vtb_item_t        item,
	output logic                      item_valid,
	input  logic                      item_ready
);

	localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int CntW = $clog2(QueueDepth + 1);

	vtb_pkg::vtb_item_t entry_q [QueueDepth];
	vtb_pkg::vtb_item_t in_item;
	logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]    count_q;
	logic               push, pop;

	// Unpack the transaction into named fields.
	always_comb begin
		in_item.pos_x       = s_tdata[31:0];
		in_item.pos_y       = s_tdata[63:32];
		in_item.pos_z       = s_tdata[95:64];
		in_item.nrm_x       = s_tdata[111:96];
		in_item.nrm_y       = s_tdata[127:112];
		in_item.nrm_z       = s_tdata[143:128];
		in_item.tex_u       = s_tdata[175:144];
		in_item.tex_v       = s_tdata[207:176];
		in_item.mesh_start  = s_tuser;
		in_item.last_vertex = s_tlast;
	end

	assign s_tready   = (count_q != CntW'(QueueDepth));
	assign item_valid = (count_q != '0);
	assign item       = entry_q[rd_ptr_q];
	assign push       = s_tvalid && s_tready;
	assign pop        = item_valid && item_ready;

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= in_item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hdl/vtb_back.sv =====
// Back part: transform, normal renormalization, bounds and result output.
// Depends on vtb_pkg.
module vtb_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  vtb_pkg::vtb_cfg_t          cfg,
	input  vtb_pkg::vtb_item_t         item,
	input  logic                       item_valid,
	output logic                       item_ready,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// out_x, out_y, out_z, out_nx, out_ny, out_nz, out_u, out_v
	output logic [vtb_pkg::DataW-1:0]  m_tdata,
	// result_kind
	output logic [vtb_pkg::KindW-1:0]  m_tuser,
	output logic                       m_tlast
);

	vtb_pkg::state_t state_q, state_d;

	vtb_pkg::vtb_item_t item_q;
	logic signed [47:0] pp_q [3][3];
	logic signed [31:0] np_q [3][3];
	logic signed [31:0] w_q [3];
	logic signed [21:0] n_q [3];
	logic [43:0]        sq_q [3];
	logic [61:0]        rad_q, root_q, bit_q;
	logic [4:0]         step_q;
	logic [30:0]        len_q;
	logic [32:0]        rem_q [3];
	logic [15:0]        low_q [3];
	logic [15:0]        quo_q [3];
	logic signed [15:0] nout_q [3];
	logic signed [31:0] bmin_q [3];
	logic signed [31:0] bmax_q [3];

	logic [vtb_pkg::DataW-1:0] m_data_q;
	logic [vtb_pkg::KindW-1:0] m_kind_q;
	logic                      m_last_q, m_valid_q;

	logic signed [31:0] pos_a [3];
	logic signed [15:0] nrm_a [3];
	logic [47:0]        row_a [3];
	logic signed [31:0] off_a [3];
	logic [43:0]        sq_sum;
	logic [61:0]        root_try;
	logic               out_free, load_out;

	assign pos_a = '{item_q.pos_x, item_q.pos_y, item_q.pos_z};
	assign nrm_a = '{item_q.nrm_x, item_q.nrm_y, item_q.nrm_z};
	assign row_a = '{cfg.row_x, cfg.row_y, cfg.row_z};
	assign off_a = '{cfg.off_x, cfg.off_y, cfg.off_z};
	assign sq_sum   = sq_q[0] + sq_q[1] + sq_q[2];
	assign root_try = root_q + bit_q;
	assign out_free = !m_valid_q || m_tready;
	assign item_ready = (state_q == vtb_pkg::ST_IDLE);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vtb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and output register load.
	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			vtb_pkg::ST_IDLE: begin
				if (item_valid) state_d = vtb_pkg::ST_MUL;
			end
			vtb_pkg::ST_MUL:  state_d = vtb_pkg::ST_SUM;
			vtb_pkg::ST_SUM:  state_d = vtb_pkg::ST_SQ;
			vtb_pkg::ST_SQ:   state_d = vtb_pkg::ST_ROOT_INIT;
			vtb_pkg::ST_ROOT_INIT: begin
				state_d = (sq_sum == '0) ? vtb_pkg::ST_EMIT_V : vtb_pkg::ST_ROOT;
			end
			vtb_pkg::ST_ROOT: begin
				if (step_q == '0) state_d = vtb_pkg::ST_DIV_INIT;
			end
			vtb_pkg::ST_DIV_INIT: state_d = vtb_pkg::ST_DIV;
			vtb_pkg::ST_DIV: begin
				if (step_q == '0) state_d = vtb_pkg::ST_FIX;
			end
			vtb_pkg::ST_FIX: state_d = vtb_pkg::ST_EMIT_V;
			vtb_pkg::ST_EMIT_V: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = item_q.last_vertex ? vtb_pkg::ST_EMIT_MIN : vtb_pkg::ST_IDLE;
				end
			end
			vtb_pkg::ST_EMIT_MIN: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = vtb_pkg::ST_EMIT_MAX;
				end
			end
			vtb_pkg::ST_EMIT_MAX: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = vtb_pkg::ST_IDLE;
				end
			end
			default: state_d = vtb_pkg::ST_IDLE;
		endcase
	end

	// Datapath: products, rounding, square root and division steps.
	always_ff @(posedge clk) begin
		logic signed [51:0] psum;
		logic signed [51:0] prnd;
		logic signed [33:0] nsum;
		logic signed [33:0] nrnd;
		logic [20:0]        mag;
		logic [46:0]        num;
		logic [33:0]        trial;
		logic [32:0]        den;
		logic signed [16:0] sq17;
		case (state_q)
			vtb_pkg::ST_IDLE: begin
				if (item_valid) item_q <= item;
			end
			vtb_pkg::ST_MUL: begin
				for (int r = 0; r < 3; r++) begin
					for (int c = 0; c < 3; c++) begin
						pp_q[r][c] <= $signed(row_a[r][16*c +: 16]) * pos_a[c];
						np_q[r][c] <= $signed(row_a[r][16*c +: 16]) * nrm_a[c];
					end
				end
			end
			vtb_pkg::ST_SUM: begin
				for (int r = 0; r < 3; r++) begin
					psum = 52'(pp_q[r][0]) + 52'(pp_q[r][1]) + 52'(pp_q[r][2])
						+ (52'(off_a[r]) <<< vtb_pkg::FracShift);
					prnd = (psum + 52'sd2048) >>> vtb_pkg::FracShift;
					if (prnd > 52'sd2147483647) begin
						w_q[r] <= 32'sh7FFF_FFFF;
					end else if (prnd < -52'sd2147483648) begin
						w_q[r] <= 32'sh8000_0000;
					end else begin
						w_q[r] <= prnd[31:0];
					end
					nsum = 34'(np_q[r][0]) + 34'(np_q[r][1]) + 34'(np_q[r][2]);
					nrnd = (nsum + 34'sd2048) >>> vtb_pkg::FracShift;
					n_q[r] <= nrnd[21:0];
				end
			end
			vtb_pkg::ST_SQ: begin
				for (int r = 0; r < 3; r++) begin
					sq_q[r] <= 44'(44'(n_q[r]) * 44'(n_q[r]));
				end
			end
			vtb_pkg::ST_ROOT_INIT: begin
				rad_q  <= {sq_sum[41:0], 20'b0};
				root_q <= '0;
				bit_q  <= 62'h1 << 60;
				step_q <= 5'd30;
				for (int r = 0; r < 3; r++) begin
					nout_q[r] <= '0;
				end
			end
			vtb_pkg::ST_ROOT: begin
				if (rad_q >= root_try) begin
					rad_q  <= rad_q - root_try;
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q  <= bit_q >> 2;
				step_q <= step_q - 1'b1;
			end
			vtb_pkg::ST_DIV_INIT: begin
				len_q  <= root_q[30:0];
				step_q <= 5'd15;
				for (int r = 0; r < 3; r++) begin
					mag = n_q[r][21] ? 21'(-n_q[r]) : n_q[r][20:0];
					num = {1'b0, mag, 25'b0} + 47'(root_q[30:0]);
					rem_q[r] <= 33'(num[46:16]);
					low_q[r] <= num[15:0];
					quo_q[r] <= '0;
				end
			end
			vtb_pkg::ST_DIV: begin
				den = {1'b0, len_q, 1'b0};
				for (int r = 0; r < 3; r++) begin
					trial = {rem_q[r], low_q[r][15]};
					if (trial >= 34'(den)) begin
						rem_q[r] <= 33'(trial - 34'(den));
						quo_q[r] <= {quo_q[r][14:0], 1'b1};
					end else begin
						rem_q[r] <= trial[32:0];
						quo_q[r] <= {quo_q[r][14:0], 1'b0};
					end
					low_q[r] <= {low_q[r][14:0], 1'b0};
				end
				step_q <= step_q - 1'b1;
			end
			vtb_pkg::ST_FIX: begin
				for (int r = 0; r < 3; r++) begin
					sq17 = n_q[r][21] ? -$signed({1'b0, quo_q[r]}) : $signed({1'b0, quo_q[r]});
					if (sq17 > 17'sd32767) begin
						nout_q[r] <= 16'sh7FFF;
					end else if (sq17 < -17'sd32768) begin
						nout_q[r] <= 16'sh8000;
					end else begin
						nout_q[r] <= sq17[15:0];
					end
				end
			end
			default: ;
		endcase
	end

	// Running bounds, updated once the world position is known.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				bmin_q[r] <= 32'sh7FFF_FFFF;
				bmax_q[r] <= 32'sh8000_0000;
			end
		end else if (state_q == vtb_pkg::ST_SQ) begin
			for (int r = 0; r < 3; r++) begin
				if (item_q.mesh_start || w_q[r] < bmin_q[r]) bmin_q[r] <= w_q[r];
				if (item_q.mesh_start || w_q[r] > bmax_q[r]) bmax_q[r] <= w_q[r];
			end
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == vtb_pkg::ST_EMIT_V) begin
				m_data_q <= {item_q.tex_v, item_q.tex_u, nout_q[2], nout_q[1], nout_q[0],
					w_q[2], w_q[1], w_q[0]};
				m_kind_q <= vtb_pkg::KIND_VERTEX;
				m_last_q <= !item_q.last_vertex;
			end else if (state_q == vtb_pkg::ST_EMIT_MIN) begin
				m_data_q <= {112'b0, bmin_q[2], bmin_q[1], bmin_q[0]};
				m_kind_q <= vtb_pkg::KIND_MIN;
				m_last_q <= 1'b0;
			end else begin
				m_data_q <= {112'b0, bmax_q[2], bmax_q[1], bmax_q[0]};
				m_kind_q <= vtb_pkg::KIND_MAX;
				m_last_q <= 1'b1;
			end
		end
	end

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

endmodule

// ===== hdl/vertex_transform_with_bounds_top.sv =====
// Top level of the vertex transform with bounds block: configuration registers,
// front queue and back sequencer. Depends on vtb_pkg, vtb_front and vtb_back.
//
// Channel   Direction  Contents
// s_*       in         one vertex per transaction; tuser mesh start, tlast last vertex
// m_*       out        vertex or bound result; tuser result_kind, tlast run_last
// cfg_*     in         register write, index 0..5, no read-back
//
// The back part works one vertex at a time through the 31-step square
// root and the 16-step divider; a zero-length normal skips both.
// A last vertex adds two result transactions. Reset clears the queue, the
// sequencer, the output valid and the bounds; configuration returns to identity.
// The front queue accepts while the back part works or the output stalls, until full.
module vertex_transform_with_bounds_top #(
	parameter int QueueDepth = vtb_pkg::QueueDepthDefault
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z, tex_u, tex_v
	input  logic [vtb_pkg::DataW-1:0]    s_tdata,
	// mesh start flag
	input  logic                         s_tuser,
	input  logic                         s_tlast,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// out_x, out_y, out_z, out_nx, out_ny, out_nz, out_u, out_v
	output logic [vtb_pkg::DataW-1:0]    m_tdata,
	// result_kind
	output logic [vtb_pkg::KindW-1:0]    m_tuser,
	output logic                         m_tlast,
	input  logic                         cfg_we,
	input  logic [vtb_pkg::CfgIdxW-1:0]  cfg_addr,
	input  logic [vtb_pkg::CfgDataW-1:0] cfg_wdata
);

	vtb_pkg::vtb_cfg_t  cfg_q;
	vtb_pkg::vtb_item_t item;
	logic               item_valid, item_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_x <= vtb_pkg::RowXReset;
			cfg_q.row_y <= vtb_pkg::RowYReset;
			cfg_q.row_z <= vtb_pkg::RowZReset;
			cfg_q.off_x <= '0;
			cfg_q.off_y <= '0;
			cfg_q.off_z <= '0;
		end else if (cfg_we) begin
			unique case (vtb_pkg::cfg_idx_t'(cfg_addr))
				vtb_pkg::CFG_ROW_X: cfg_q.row_x <= cfg_wdata;
				vtb_pkg::CFG_ROW_Y: cfg_q.row_y <= cfg_wdata;
				vtb_pkg::CFG_ROW_Z: cfg_q.row_z <= cfg_wdata;
				vtb_pkg::CFG_OFF_X: cfg_q.off_x <= cfg_wdata[31:0];
				vtb_pkg::CFG_OFF_Y: cfg_q.off_y <= cfg_wdata[31:0];
				vtb_pkg::CFG_OFF_Z: cfg_q.off_z <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	vtb_front #(
		.QueueDepth(QueueDepth)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.item      (item),
		.item_valid(item_valid),
		.item_ready(item_ready)
	);

	vtb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.item      (item),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== tb/sv/tb_vertex_transform_with_bounds_top.sv =====
// Self-checking testbench for vertex_transform_with_bounds_top: directed and random
// vertex streams, with a bit-exact transform and bounds predictor kept alongside.
// Depends on vtb_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_vertex_transform_with_bounds_top;
	import vtb_pkg::*;

	localparam int IdleLimit = 8000;
	localparam int HoldCycles = 500;

	// One input vertex, in the block's field widths.
	typedef struct {
		logic signed [31:0] pos_x, pos_y, pos_z;
		logic signed [15:0] nrm_x, nrm_y, nrm_z;
		logic [31:0]        tex_u, tex_v;
		logic               mesh_start, last_vertex;
	} vertex_t;

	// One result transaction.
	typedef struct {
		kind_t              kind;
		logic signed [31:0] x, y, z;
		logic signed [15:0] nx, ny, nz;
		logic [31:0]        u, v;
		logic               run_last;
	} vtx_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DataW-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DataW-1:0] m_tdata;
	logic [KindW-1:0] m_tuser;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_addr = '0;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	// Predictor copy of the configuration and the running bounds.
	logic [RowW-1:0] mdl_row [3];
	logic signed [31:0] mdl_off [3];
	logic signed [31:0] mdl_min [3];
	logic signed [31:0] mdl_max [3];

	vtx_result_t expected_results [$];
	int mismatches = 0;
	int vertices_sent = 0;
	int results_checked = 0;
	int idle_cycles = 0;
	int rx_hold = 0;
	bit tx_gaps = 1'b0;
	bit rx_stalls = 1'b0;

	vertex_transform_with_bounds_top u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	// Coefficient k of a packed row, as a signed Q3.12 value.
	function automatic longint coef(logic [RowW-1:0] row, int k);
		return longint'($signed(row[16*k +: 16]));
	endfunction

	function automatic longint row_dot(logic [RowW-1:0] row, longint a, longint b, longint c);
		return coef(row, 0) * a + coef(row, 1) * b + coef(row, 2) * c;
	endfunction

	// Round half toward plus infinity, dropping twelve fraction bits.
	function automatic longint round12(longint v);
		return (v + 64'sd2048) >>> 12;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// One unit-normal component, rounded half away from zero, saturated to Q1.14.
	function automatic logic signed [15:0] unit_comp(longint n, longint unsigned len);
		longint unsigned mag;
		longint q;
		mag = (n < 0) ? longint'(-n) : longint'(n);
		q = longint'((mag * (64'd1 << 25) + len) / (2 * len));
		if (n < 0) q = -q;
		return 16'(clamp(q, -32768, 32767));
	endfunction

	// Works out the results of one accepted vertex and updates the bounds.
	task automatic predict_vertex(vertex_t vx);
		vtx_result_t r;
		logic signed [31:0] w [3];
		longint n [3];
		longint unsigned sq;
		longint unsigned len;
		for (int a = 0; a < 3; a++) begin
			w[a] = 32'(clamp(round12(row_dot(mdl_row[a], vx.pos_x, vx.pos_y, vx.pos_z)
				+ longint'(mdl_off[a]) * 4096), -64'sd2147483648, 64'sd2147483647));
			n[a] = round12(row_dot(mdl_row[a], vx.nrm_x, vx.nrm_y, vx.nrm_z));
		end
		sq = longint'(n[0] * n[0] + n[1] * n[1] + n[2] * n[2]);
		r.kind = KIND_VERTEX;
		r.x = w[0];
		r.y = w[1];
		r.z = w[2];
		r.nx = '0;
		r.ny = '0;
		r.nz = '0;
		if (sq != 0) begin
			len = int_sqrt(sq << 20);
			r.nx = unit_comp(n[0], len);
			r.ny = unit_comp(n[1], len);
			r.nz = unit_comp(n[2], len);
		end
		r.u = vx.tex_u;
		r.v = vx.tex_v;
		r.run_last = ~vx.last_vertex;
		for (int a = 0; a < 3; a++) begin
			if (vx.mesh_start) begin
				mdl_min[a] = w[a];
				mdl_max[a] = w[a];
			end else begin
				if (w[a] < mdl_min[a]) mdl_min[a] = w[a];
				if (w[a] > mdl_max[a]) mdl_max[a] = w[a];
			end
		end
		expected_results.insert(expected_results.size(), r);
		if (vx.last_vertex) begin
			r = '{KIND_MIN, mdl_min[0], mdl_min[1], mdl_min[2], 0, 0, 0, 0, 0, 1'b0};
			expected_results.insert(expected_results.size(), r);
			r = '{KIND_MAX, mdl_max[0], mdl_max[1], mdl_max[2], 0, 0, 0, 0, 0, 1'b1};
			expected_results.insert(expected_results.size(), r);
		end
	endtask

	// Offers one vertex and waits for its transaction; valid stays high afterwards.
	task automatic send_vertex(vertex_t vx);
		int gap;
		if (tx_gaps && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 11);
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata = {vx.tex_v, vx.tex_u, vx.nrm_z, vx.nrm_y, vx.nrm_x,
			vx.pos_z, vx.pos_y, vx.pos_x};
		s_tuser = vx.mesh_start;
		s_tlast = vx.last_vertex;
		do @(posedge clk); while (!s_tready);
		predict_vertex(vx);
		vertices_sent++;
	endtask

	// Lowers valid and waits until every expected result has been seen.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		wait (expected_results.size() == 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CfgDataW-1:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = idx;
		cfg_wdata = value;
		@(posedge clk);
		case (idx)
			CFG_ROW_X: mdl_row[0] = value;
			CFG_ROW_Y: mdl_row[1] = value;
			CFG_ROW_Z: mdl_row[2] = value;
			CFG_OFF_X: mdl_off[0] = value[31:0];
			CFG_OFF_Y: mdl_off[1] = value[31:0];
			CFG_OFF_Z: mdl_off[2] = value[31:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic write_all(logic [RowW-1:0] rx, logic [RowW-1:0] ry, logic [RowW-1:0] rz,
		logic [31:0] ox, logic [31:0] oy, logic [31:0] oz);
		write_reg(CFG_ROW_X, rx);
		write_reg(CFG_ROW_Y, ry);
		write_reg(CFG_ROW_Z, rz);
		write_reg(CFG_OFF_X, ox);
		write_reg(CFG_OFF_Y, oy);
		write_reg(CFG_OFF_Z, oz);
	endtask

	function automatic vertex_t make_vertex(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
		logic [15:0] nx, logic [15:0] ny, logic [15:0] nz, bit first, bit last);
		vertex_t vx;
		vx = '{px, py, pz, nx, ny, nz, $urandom, $urandom, first, last};
		return vx;
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 16'h1000 : 16'hF000;
			1: return 16'($urandom_range(0, 16383) - 8192);
			2: return 16'h0000;
			3: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 3))
			0: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
			1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [15:0] rand_nrm();
		case ($urandom_range(0, 3))
			0: return 16'($urandom_range(0, 8)) - 16'd4;
			1: return 16'($urandom_range(0, 32767)) - 16'd16384;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic vertex_t rand_vertex(bit first, bit last);
		return make_vertex(rand_word(), rand_word(), rand_word(),
			rand_nrm(), rand_nrm(), rand_nrm(), first, last);
	endfunction

	task automatic random_config();
		write_all({rand_coef(), rand_coef(), rand_coef()}, {rand_coef(), rand_coef(), rand_coef()},
			{rand_coef(), rand_coef(), rand_coef()}, rand_word(), rand_word(), rand_word());
	endtask

	// Sends one mesh: a first vertex, any middle ones and a last vertex; a count of one sends a vertex that is both.
	task automatic send_mesh(int count);
		for (int i = 0; i < count; i++)
			send_vertex(rand_vertex(i == 0, i == count - 1));
	endtask

	// Bounds restart and emission at identity, with field extremes.
	task automatic test_identity_extremes();
		// A last vertex straight after reset updates the reset bounds.
		send_vertex(make_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 16'h4000, 0, 0, 0, 1));
		send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'h7FFF, 16'h8000, 16'h7FFF,
			1, 0));
		send_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 16'h8000, 16'h8000,
			16'h8000, 0, 0));
		// Zero-length normal.
		send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h0, 0, 0));
		send_vertex('{32'h1234_5678, 32'h0, 32'h1, 16'h0001, 16'hFFFF, 16'h0, 32'hFFFF_FFFF,
			32'h0, 1'b0, 1'b1});
		send_vertex('{32'h0, 32'h0, 32'h0, 16'h0, 16'h0, 16'h2D41, 32'h0, 32'hFFFF_FFFF,
			1'b0, 1'b0});
		// First and last on one vertex.
		send_vertex(make_vertex(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h5555_5555, 16'h1111, 16'hAAAA,
			16'h5555, 1, 1));
		drain();
	endtask

	// Saturating coefficients and offsets, and normals that round to nothing.
	task automatic test_config_extremes();
		write_all({3{16'h7FFF}}, {3{16'h8000}}, 48'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 1, 0));
		send_vertex(make_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h8000,
			16'h8000, 0, 0));
		send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 16'h0100, 16'h0, 16'h0, 0, 1));
		drain();
		write_all({3{16'h0001}}, {3{16'hFFFF}}, 48'h0001_0000_0000, 32'h0, 32'hFFFF_FFFF,
			32'h0001_0000);
		send_vertex(make_vertex(32'h0000_0800, 32'hFFFF_F800, 32'h0000_07FF, 16'h0001, 16'h0000,
			16'h0000, 1, 0));
		send_vertex(make_vertex(32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 16'h0800, 16'h0000, 16'h0000,
			0, 0));
		send_vertex(make_vertex(32'h0, 32'h0, 32'h0, 16'h0800, 16'h0800, 16'h0, 0, 1));
		drain();
		write_all({16'h0, 16'h0, 16'h1000}, {16'h0, 16'h1000, 16'h0}, {16'h1000, 16'h0, 16'h0},
			32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 16'h7FFF, 16'h0, 16'h8000,
			1, 1));
		drain();
	endtask

	// Receiver holds off for a long stretch while vertices keep coming.
	task automatic test_backpressure();
		rx_hold = HoldCycles;
		send_mesh(12);
		drain();
	endtask

	// Random meshes under random configurations, with some unframed vertices.
	task automatic test_random_meshes(int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			if ($urandom_range(0, 3) == 0) begin
				drain();
				random_config();
			end
			if ($urandom_range(0, 4) == 0) begin
				send_vertex(rand_vertex($urandom_range(0, 1), $urandom_range(0, 1)));
				sent++;
			end else begin
				automatic int count = $urandom_range(1, 10);
				send_mesh(count);
				sent += count;
			end
		end
		drain();
	endtask

	// Receiver: random stall bursts, or a long hold-off when one is asked for.
	always begin
		@(negedge clk);
		if (rx_hold > 0) begin
			m_tready = 1'b0;
			rx_hold--;
		end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
			m_tready = 1'b0;
			repeat ($urandom_range(1, 11) - 1) @(negedge clk);
		end else begin
			m_tready = 1'b1;
		end
	end

	// Compares each result transaction with the oldest expectation.
	always @(posedge clk) begin
		vtx_result_t got;
		vtx_result_t want;
		string bad;
		if (arst_n && m_tvalid && m_tready) begin
			got = '{kind_t'(m_tuser), m_tdata[31:0], m_tdata[63:32], m_tdata[95:64],
				m_tdata[111:96], m_tdata[127:112], m_tdata[143:128], m_tdata[175:144],
				m_tdata[207:176], m_tlast};
			results_checked++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result transaction: kind %0d x %h", got.kind, got.x);
			end else begin
				want = expected_results.pop_front();
				bad = "";
				if (got.kind != want.kind) bad = {bad, " kind"};
				if (got.x != want.x) bad = {bad, " x"};
				if (got.y != want.y) bad = {bad, " y"};
				if (got.z != want.z) bad = {bad, " z"};
				if (got.nx != want.nx) bad = {bad, " nx"};
				if (got.ny != want.ny) bad = {bad, " ny"};
				if (got.nz != want.nz) bad = {bad, " nz"};
				if (got.u != want.u) bad = {bad, " u"};
				if (got.v != want.v) bad = {bad, " v"};
				if (got.run_last != want.run_last) bad = {bad, " last"};
				if (bad != "") begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("Mismatch in%s at %0t", bad, $realtime);
						$display("  expected %0d %h %h %h %h %h %h %h %h %b", want.kind, want.x,
							want.y, want.z, want.nx, want.ny, want.nz, want.u, want.v,
							want.run_last);
						$display("  actual   %0d %h %h %h %h %h %h %h %h %b", got.kind, got.x,
							got.y, got.z, got.nx, got.ny, got.nz, got.u, got.v, got.run_last);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IdleLimit) begin
			$display("Timeout: no transaction for %0d cycles", IdleLimit);
			$display("tb_vertex_transform_with_bounds_top: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		mdl_row[0] = RowXReset;
		mdl_row[1] = RowYReset;
		mdl_row[2] = RowZReset;
		for (int a = 0; a < 3; a++) begin
			mdl_off[a] = '0;
			mdl_min[a] = 32'h7FFF_FFFF;
			mdl_max[a] = 32'h8000_0000;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_identity_extremes();
		test_config_extremes();
		tx_gaps = 1'b1;
		rx_stalls = 1'b1;
		test_backpressure();
		test_random_meshes(260);
		tx_gaps = 1'b0;
		rx_stalls = 1'b0;
		test_random_meshes(70);

		@(negedge clk);
		s_tvalid = 1'b0;
		wait (expected_results.size() == 0);
		repeat (80) @(posedge clk);
		$display("Sent %0d vertices and checked %0d results over directed, saturating,",
			vertices_sent, results_checked);
		$display("back-pressured and random mesh phases; %0d mismatches.", mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("tb_vertex_transform_with_bounds_top: clean");
		else
			$display("tb_vertex_transform_with_bounds_top: errors");
		$finish;
	end

endmodule

// ===== vertex_transform_with_bounds_top.f =====
hdl/vtb_pkg.sv
hdl/vtb_front.sv
hdl/vtb_back.sv
hdl/vertex_transform_with_bounds_top.sv
tb/sv/tb_vertex_transform_with_bounds_top.sv
